// ----- src/dofs_pkg.sv -----
// ----------------------------------------------------------------------------
// Date offset calculator package
// Shared types, constants and calendar tables for the date offset block.
// ----------------------------------------------------------------------------
package dofs_pkg;

  localparam logic [15:0] YEAR_MIN   = 16'd1600;
  localparam logic [27:0] LOW_SERIAL = 28'd584023;
  localparam logic [16:0] RECIP25    = 17'd83887;
  localparam logic [7:0]  RECIP5     = 8'd205;
  localparam logic [18:0] RECIP3     = 19'd349526;
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [3:0]  MONTHS     = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WAIT, ST_D1A, ST_D1B, ST_D1C,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5,
    ST_B0, ST_B1, ST_C0, ST_M0
  } state_t;

  typedef struct packed {
    logic        start;
    logic [17:0] n;
  } yu_req_t;

  typedef struct packed {
    logic        done;
    logic        lp;
    logic [15:0] lcount;
    logic [26:0] y365;
  } yu_resp_t;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = lp ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/dofs_year_unit.sv -----
// ----------------------------------------------------------------------------
// Year unit
// Three-stage pipeline giving 365*n, the leap years up to n and whether n is
// a leap year, using reciprocal multiplications for the century rules.
// ----------------------------------------------------------------------------
module dofs_year_unit
  import dofs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  yu_req_t  req,
  output yu_resp_t resp
);

  logic        s1_v;
  logic [17:0] s1_n;
  logic [32:0] s1_prod;
  logic        s2_v;
  logic [17:0] s2_n;
  logic [11:0] s2_a;
  logic        s2_d4;
  logic        s2_d100;
  logic        s2_d400;
  logic [16:0] s2_prod;

  logic [15:0] x1;
  logic [11:0] a1;
  logic [15:0] a25;
  logic [15:0] x2;
  logic [6:0]  c2;
  logic [8:0]  a8;
  logic [8:0]  c5;
  logic        d4000;
  logic        lp_c;
  logic [15:0] lc;
  logic [26:0] n365;

  assign x1  = s1_n[17:2];
  assign a1  = s1_prod[32:21];
  assign a25 = 16'({a1, 4'b0}) + 16'({a1, 3'b0}) + 16'(a1);

  assign x2    = s2_n[17:2];
  assign c2    = s2_prod[16:10];
  assign a8    = s2_a[11:3];
  assign c5    = 9'({c2, 2'b0}) + 9'(c2);
  assign d4000 = s2_d400 && (s2_a[2:0] == 3'd0) && (a8 == c5);
  assign lp_c  = d4000 ? 1'b0 : s2_d400 ? 1'b1 : s2_d100 ? 1'b0 : s2_d4;
  assign lc    = x2 - 16'(s2_a) + 16'(s2_a[11:2]) - 16'(c2);
  assign n365  = 27'({s2_n, 8'b0}) + 27'({s2_n, 6'b0}) + 27'({s2_n, 5'b0})
               + 27'({s2_n, 3'b0}) + 27'({s2_n, 2'b0}) + 27'(s2_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      resp.done <= 1'b0;
    end else begin
      s1_v      <= req.start;
      s2_v      <= s1_v;
      resp.done <= s2_v;
      if (s2_v) begin
        resp.lp     <= lp_c;
        resp.lcount <= lc;
        resp.y365   <= n365;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      s1_n    <= req.n;
      s1_prod <= 33'(req.n[17:2]) * 33'(RECIP25);
    end
    if (s1_v) begin
      s2_n    <= s1_n;
      s2_a    <= a1;
      s2_d4   <= (s1_n[1:0] == 2'd0);
      s2_d100 <= (s1_n[1:0] == 2'd0) && (x1 == a25);
      s2_d400 <= (s1_n[1:0] == 2'd0) && (x1 == a25) && (a1[1:0] == 2'd0);
      s2_prod <= 17'(a1[11:3]) * 17'(RECIP5);
    end
  end

endmodule

// ----- src/date_offset_add.sv -----
// ----------------------------------------------------------------------------
// Date offset calculator
// Adds signed year, month and day offsets to a Gregorian date (years
// divisible by 4000 not leap), or gives the day difference of two dates.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the single result appears on the result ports with done high for
// one cycle, which the receiver must take there and then. All calendar work
// goes through one three-stage year unit. An addition runs the 18-step
// binary search for the year of the final day count, followed by month steps.
module date_offset_add
  import dofs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               command,
  input  logic [15:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [15:0]        other_year,
  input  logic [3:0]         other_month,
  input  logic [4:0]         other_day,
  input  logic signed [16:0] year_offset,
  input  logic signed [16:0] month_offset,
  input  logic signed [24:0] day_offset,
  output logic [15:0]        result_year,
  output logic [3:0]         result_month,
  output logic [4:0]         result_day,
  output logic signed [25:0] day_difference,
  output logic               invalid
);

  state_t      state, state_next, ret, ret_next;
  yu_req_t     ureq;
  yu_resp_t    uresp;
  logic        issue;
  logic [17:0] un_next;
  logic        fin, fin_bad;

  logic        cmd;
  logic [15:0] yr, oy;
  logic [3:0]  mo, om, mw;
  logic [4:0]  dy, od;
  logic [16:0] yoff, moff;
  logic [24:0] doff;
  logic [18:0] ys;
  logic [20:0] total;
  logic [37:0] prod;
  logic [27:0] sreg, dn;
  logic [17:0] nsrch;
  logic [4:0]  bitpos;
  logic [25:0] acc;
  logic [8:0]  rem;

  logic [18:0] y1;
  logic [21:0] ysx, tot;
  logic [17:0] q;
  logic [20:0] r12;
  logic [27:0] sv, dval, rdiff;
  logic [4:0]  ml_a, ml_w;
  logic [15:0] sel_y;
  logic [3:0]  sel_m;
  logic [4:0]  sel_d;
  logic [25:0] dcnt;
  logic [17:0] base;
  logic        a1_ok, y1_ok, b_take;

  assign busy       = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ureq.start <= 1'b0;
      ureq.n     <= '0;
    end else begin
      ureq.start <= issue;
      if (issue) begin
        ureq.n <= un_next;
      end
    end
  end

  dofs_year_unit u_year (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .resp (uresp)
  );

  assign y1    = 19'(yr) + {{2{yoff[16]}}, yoff};
  assign ml_a  = month_len(mo, uresp.lp);
  assign ml_w  = month_len(mw, uresp.lp);
  assign a1_ok = (mo >= 4'd1) && (mo <= MONTHS) && (dy != 5'd0) && (yr >= YEAR_MIN)
               && (dy <= ml_a);
  assign y1_ok = !y1[18] && (y1 >= 19'(YEAR_MIN));
  assign ysx   = {{3{ys[18]}}, ys};
  assign tot   = (ysx << 3) + (ysx << 2) + 22'(mo) - 22'd1 + {{5{moff[16]}}, moff};
  assign q     = prod[37:20];
  assign r12   = total - 21'({q, 3'b0}) - 21'({q, 2'b0});
  assign sv    = {1'b0, uresp.y365} - 28'(YEAR_DAYS) + 28'(uresp.lcount) - 28'(uresp.lp)
               + 28'(days_before(mw)) + 28'(dy) + 28'((mw > 4'd2) && uresp.lp)
               + {{3{doff[24]}}, doff};
  assign dval  = {1'b0, uresp.y365} + 28'(uresp.lcount);
  assign b_take = (dval < sreg);
  assign rdiff = sreg - dn;

  assign sel_y = (state == ST_D1C || state == ST_D1A) ? ((state == ST_D1A) ? yr : oy)
               : ((state == ST_D1B) ? yr : oy);
  assign sel_m = (state == ST_D1C) ? om : mo;
  assign sel_d = (state == ST_D1C) ? od : dy;
  assign dcnt  = 26'(uresp.y365) + (((sel_m <= 4'd2) && (sel_y != 16'd0)) ? 26'd365 : 26'd0)
               + 26'(days_before(sel_m)) + 26'(sel_d) + 26'(uresp.lcount);

  always_comb begin
    logic [15:0] by;
    logic [3:0]  bm;
    by = (state == ST_D1A) ? yr : oy;
    bm = (state == ST_D1A) ? mo : om;
    if (bm <= 4'd2) begin
      base = (by == 16'd0) ? 18'd0 : 18'(by - 16'd1);
    end else begin
      base = 18'(by);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    issue      = 1'b0;
    un_next    = '0;
    fin        = 1'b0;
    fin_bad    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = command ? ST_D1A : ST_A0;
        end
      end
      ST_WAIT: begin
        if (uresp.done) begin
          state_next = ret;
        end
      end
      ST_D1A: begin
        issue = 1'b1; un_next = base; ret_next = ST_D1B; state_next = ST_WAIT;
      end
      ST_D1B: begin
        issue = 1'b1; un_next = base; ret_next = ST_D1C; state_next = ST_WAIT;
      end
      ST_D1C: begin
        fin = 1'b1; state_next = ST_IDLE;
      end
      ST_A0: begin
        issue = 1'b1; un_next = 18'(yr); ret_next = ST_A1; state_next = ST_WAIT;
      end
      ST_A1: begin
        if (!a1_ok || !y1_ok) begin
          fin = 1'b1; fin_bad = 1'b1; state_next = ST_IDLE;
        end else begin
          issue = 1'b1; un_next = y1[17:0]; ret_next = ST_A2; state_next = ST_WAIT;
        end
      end
      ST_A2: begin
        if ((dy > ml_a) || tot[21]) begin
          fin = 1'b1; fin_bad = 1'b1; state_next = ST_IDLE;
        end else begin
          state_next = ST_A3;
        end
      end
      ST_A3: begin
        state_next = ST_A4;
      end
      ST_A4: begin
        if (q < 18'(YEAR_MIN)) begin
          fin = 1'b1; fin_bad = 1'b1; state_next = ST_IDLE;
        end else begin
          issue = 1'b1; un_next = q; ret_next = ST_A5; state_next = ST_WAIT;
        end
      end
      ST_A5: begin
        if ((dy > ml_w) || $signed(sv) < $signed(LOW_SERIAL)) begin
          fin = 1'b1; fin_bad = 1'b1; state_next = ST_IDLE;
        end else begin
          state_next = ST_B0;
        end
      end
      ST_B0: begin
        issue = 1'b1; un_next = nsrch | (18'd1 << bitpos);
        ret_next = ST_B1; state_next = ST_WAIT;
      end
      ST_B1: begin
        state_next = (bitpos == 5'd0) ? ST_C0 : ST_B0;
      end
      ST_C0: begin
        if (nsrch >= 18'd65535) begin
          fin = 1'b1; fin_bad = 1'b1; state_next = ST_IDLE;
        end else begin
          issue = 1'b1; un_next = nsrch + 18'd1; ret_next = ST_M0; state_next = ST_WAIT;
        end
      end
      ST_M0: begin
        if (!((mw < MONTHS) && (rem > 9'(ml_w)))) begin
          fin = 1'b1; state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd  <= command;
          yr   <= year;
          mo   <= month;
          dy   <= day;
          oy   <= other_year;
          om   <= other_month;
          od   <= other_day;
          yoff <= year_offset;
          moff <= month_offset;
          doff <= day_offset;
        end
      end
      ST_D1B: acc <= dcnt;
      ST_A1:  ys <= y1;
      ST_A2:  total <= tot[20:0];
      ST_A3:  prod <= 38'(total[20:2]) * 38'(RECIP3);
      ST_A4: begin
        ys <= 19'(q);
        mw <= r12[3:0] + 4'd1;
      end
      ST_A5: begin
        sreg   <= sv;
        nsrch  <= '0;
        dn     <= '0;
        bitpos <= 5'd17;
      end
      ST_B1: begin
        if (b_take) begin
          nsrch <= ureq.n;
          dn    <= dval;
        end
        bitpos <= bitpos - 5'd1;
      end
      ST_C0: begin
        rem <= rdiff[8:0];
        ys  <= 19'(nsrch + 18'd1);
        mw  <= 4'd1;
      end
      ST_M0: begin
        if ((mw < MONTHS) && (rem > 9'(ml_w))) begin
          rem <= rem - 9'(ml_w);
          mw  <= mw + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      if (cmd) begin
        result_year    <= '0;
        result_month   <= '0;
        result_day     <= '0;
        invalid        <= 1'b0;
        day_difference <= $signed(acc - dcnt);
      end else begin
        day_difference <= '0;
        invalid        <= fin_bad;
        result_year    <= fin_bad ? 16'd0 : ys[15:0];
        result_month   <= fin_bad ? 4'd0 : mw;
        result_day     <= fin_bad ? 5'd0 : rem[4:0];
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result presented while still busy");
  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("transaction taken without going busy");
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    done && invalid |-> result_year == 16'd0 && result_month == 4'd0 && result_day == 5'd0)
    else $error("invalid result carries a date");
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    done && result_month != 4'd0 |-> result_month <= MONTHS && result_day != 5'd0
      && result_year >= YEAR_MIN)
    else $error("result date out of range");

endmodule
